/* rtl/m68k_ocd_pkg.sv */
package m68k_ocd_pkg;

    // Instruction class codes, dense, in decode-tree order
    typedef enum logic [6:0] {
        K_ILLEGAL, K_MOVEP, K_BTST_D, K_BCHG_D, K_BCLR_D, K_BSET_D,
        K_ORI_CCR, K_ORI_SR, K_ORI, K_ANDI_CCR, K_ANDI_SR, K_ANDI,
        K_SUBI, K_ADDI, K_BTST_S, K_BCHG_S, K_BCLR_S, K_BSET_S,
        K_EORI_CCR, K_EORI_SR, K_EORI, K_CMPI, K_MOVEA, K_MOVE,
        K_LEA, K_CHK, K_MOVE_FROM_SR, K_MOVE_TO_CCR, K_MOVE_TO_SR,
        K_NEGX, K_CLR, K_NEG, K_NOT, K_EXT, K_NBCD, K_SWAP, K_PEA,
        K_MOVEM, K_TAS, K_TST, K_TRAP, K_LINK, K_UNLK, K_MOVE_USP,
        K_RESET, K_NOP, K_STOP, K_RTE, K_RTS, K_TRAPV, K_RTR,
        K_JSR, K_JMP, K_DBCC, K_SCC, K_SUBAQ, K_ADDAQ, K_SUBQ, K_ADDQ,
        K_BCC_W, K_BCC_S, K_BSR_W, K_BSR_S, K_BRA_W, K_BRA_S,
        K_MOVEQ, K_DIVS, K_DIVU, K_SBCD, K_OR, K_SUBA, K_SUBX, K_SUB,
        K_LINE_A, K_CMPA, K_CMP, K_CMPM, K_EOR, K_MULS, K_MULU,
        K_ABCD, K_EXG, K_AND, K_ADDA, K_ADDX, K_ADD,
        K_ASD_M, K_LSD_M, K_ROXD_M, K_ROD_M,
        K_ASD_R, K_LSD_R, K_ROXD_R, K_ROD_R, K_LINE_F
    } class_t;

    // Opcode line numbers (top nibble) with special handling
    localparam logic [3:0] LINE_BITS = 4'h0;
    localparam logic [3:0] LINE_MISC = 4'h4;

    // Predecoded opcode, first pipeline stage
    typedef struct packed {
        logic [15:0] word;
        logic        imm;       // mode 7, reg 4: immediate source
        logic        areg;      // mode 1: address register direct
        logic        word_disp; // low byte zero: 16-bit branch displacement
    } pre_t;

    // Per-group candidate classes, second pipeline stage
    typedef struct packed {
        logic [15:0] word;
        class_t      bits_class;
        class_t      misc_class;
        class_t      rest_class;
    } cand_t;

endpackage

/* rtl/m68k_opcode_class_decoder.sv */
// 68000 opcode class decoder: opcode word in, class code and split fields out.
// Throughput: one opcode per cycle while result_stall is low; three register stages
// (predecode, group decode, line select) each hold a valid bit and advance independently under stall.
// Reset (rst_n low, asynchronous) clears all stage valid bits; payload is not reset.
module m68k_opcode_class_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        opcode_valid,
    output logic        opcode_stall,
    input  logic [15:0] opcode_word,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [6:0]  instruction_code,
    output logic [2:0]  ea_register,
    output logic [2:0]  ea_mode,
    output logic [2:0]  second_mode,
    output logic [2:0]  second_register,
    output logic [1:0]  size_bits,
    output logic        bit_eight
);
    import m68k_ocd_pkg::*;

    // Immediate to CCR/SR selection shared by ORI, ANDI and EORI
    function automatic class_t imm_class(input logic to_sr, input logic [1:0] sz,
                                         input class_t ccr, input class_t sr,
                                         input class_t plain);
        class_t c;
        if (!to_sr)
            c = plain;
        else if (sz == 2'd0)
            c = ccr;
        else if (sz == 2'd1)
            c = sr;
        else
            c = K_ILLEGAL;
        return c;
    endfunction

    // Line 0: bit operations, MOVEP and immediates
    function automatic class_t decode_bits(input pre_t p);
        class_t c;
        logic [1:0] sz;
        sz = p.word[7:6];
        if (p.word[8]) begin
            if (p.areg)
                c = K_MOVEP;
            else begin
                unique case (sz)
                    2'd0: c = K_BTST_D;
                    2'd1: c = K_BCHG_D;
                    2'd2: c = K_BCLR_D;
                    default: c = K_BSET_D;
                endcase
            end
        end
        else begin
            unique case (p.word[11:9])
                3'd0: c = imm_class(p.imm, sz, K_ORI_CCR, K_ORI_SR, K_ORI);
                3'd1: c = imm_class(p.imm, sz, K_ANDI_CCR, K_ANDI_SR, K_ANDI);
                3'd2: c = K_SUBI;
                3'd3: c = K_ADDI;
                3'd4:
                begin
                    unique case (sz)
                        2'd0: c = K_BTST_S;
                        2'd1: c = K_BCHG_S;
                        2'd2: c = K_BCLR_S;
                        default: c = K_BSET_S;
                    endcase
                end
                3'd5: c = imm_class(p.imm, sz, K_EORI_CCR, K_EORI_SR, K_EORI);
                3'd6: c = K_CMPI;
                default: c = K_ILLEGAL;
            endcase
        end
        return c;
    endfunction

    // Line 4: miscellaneous group
    function automatic class_t decode_misc(input pre_t p);
        class_t c;
        logic [15:0] w;
        w = p.word;
        if (w[8]) begin
            if (w[7:6] == 2'd3)
                c = K_LEA;
            else if (w[7:6] == 2'd2)
                c = K_CHK;
            else
                c = K_ILLEGAL;
        end
        else if (!w[11]) begin
            if (w[7:6] == 2'd3) begin
                unique case (w[11:9])
                    3'd0: c = K_MOVE_FROM_SR;
                    3'd2: c = K_MOVE_TO_CCR;
                    3'd3: c = K_MOVE_TO_SR;
                    default: c = K_ILLEGAL;
                endcase
            end
            else begin
                unique case (w[10:9])
                    2'd0: c = K_NEGX;
                    2'd1: c = K_CLR;
                    2'd2: c = K_NEG;
                    default: c = K_NOT;
                endcase
            end
        end
        else if (!w[9]) begin
            priority if ((w & 16'h01B8) == 16'h0080) c = K_EXT;
            else if ((w & 16'h01C0) == 16'h0000) c = K_NBCD;
            else if ((w & 16'h01F8) == 16'h0040) c = K_SWAP;
            else if ((w & 16'h01C0) == 16'h0040) c = K_PEA;
            else if ((w & 16'h0B80) == 16'h0880) c = K_MOVEM;
            else c = K_ILLEGAL;
        end
        else begin
            // ILLEGAL and reserved words 4AFA..4AFC sit inside the TAS pattern
            priority if (w == 16'h4AFA || w == 16'h4AFB || w == 16'h4AFC) c = K_ILLEGAL;
            else if ((w & 16'h0FC0) == 16'h0AC0) c = K_TAS;
            else if ((w & 16'h0F00) == 16'h0A00) c = K_TST;
            else if ((w & 16'h0FF0) == 16'h0E40) c = K_TRAP;
            else if ((w & 16'h0FF8) == 16'h0E50) c = K_LINK;
            else if ((w & 16'h0FF8) == 16'h0E58) c = K_UNLK;
            else if ((w & 16'h0FF0) == 16'h0E60) c = K_MOVE_USP;
            else if ((w & 16'h0FF8) == 16'h0E70) begin
                unique case (w[2:0])
                    3'd0: c = K_RESET;
                    3'd1: c = K_NOP;
                    3'd2: c = K_STOP;
                    3'd3: c = K_RTE;
                    3'd5: c = K_RTS;
                    3'd6: c = K_TRAPV;
                    3'd7: c = K_RTR;
                    default: c = K_ILLEGAL;
                endcase
            end
            else if ((w & 16'h0FC0) == 16'h0E80) c = K_JSR;
            else if ((w & 16'h0FC0) == 16'h0EC0) c = K_JMP;
            else c = K_ILLEGAL;
        end
        return c;
    endfunction

    // All other lines
    function automatic class_t decode_rest(input pre_t p);
        class_t c;
        logic [15:0] w;
        logic sz3;
        logic xform;
        w = p.word;
        sz3 = (w[7:6] == 2'd3);
        xform = ((w & 16'h0130) == 16'h0100);
        unique case (w[15:12])
            4'h1, 4'h2, 4'h3: c = ((w & 16'h01C0) == 16'h0040) ? K_MOVEA : K_MOVE;
            4'h5:
            begin
                if (sz3)
                    c = p.areg ? K_DBCC : K_SCC;
                else if (p.areg)
                    c = w[8] ? K_SUBAQ : K_ADDAQ;
                else
                    c = w[8] ? K_SUBQ : K_ADDQ;
            end
            4'h6:
            begin
                if (w[11:9] != 3'd0)
                    c = p.word_disp ? K_BCC_W : K_BCC_S;
                else if (w[8])
                    c = p.word_disp ? K_BSR_W : K_BSR_S;
                else
                    c = p.word_disp ? K_BRA_W : K_BRA_S;
            end
            4'h7: c = K_MOVEQ;
            4'h8:
            begin
                if (sz3)
                    c = w[8] ? K_DIVS : K_DIVU;
                else
                    c = ((w & 16'h0170) == 16'h0100) ? K_SBCD : K_OR;
            end
            4'h9: c = sz3 ? K_SUBA : (xform ? K_SUBX : K_SUB);
            4'hA: c = K_LINE_A;
            4'hB:
            begin
                if (sz3)
                    c = K_CMPA;
                else if (!w[8])
                    c = K_CMP;
                else
                    c = p.areg ? K_CMPM : K_EOR;
            end
            4'hC:
            begin
                if (sz3)
                    c = w[8] ? K_MULS : K_MULU;
                else if (xform)
                    c = (w[7:6] == 2'd0) ? K_ABCD : K_EXG;
                else
                    c = K_AND;
            end
            4'hD: c = sz3 ? K_ADDA : (xform ? K_ADDX : K_ADD);
            4'hE:
            begin
                if (sz3) begin
                    unique case (w[11:9])
                        3'd0: c = K_ASD_M;
                        3'd1: c = K_LSD_M;
                        3'd2: c = K_ROXD_M;
                        3'd3: c = K_ROD_M;
                        default: c = K_ILLEGAL;
                    endcase
                end
                else begin
                    unique case (w[4:3])
                        2'd0: c = K_ASD_R;
                        2'd1: c = K_LSD_R;
                        2'd2: c = K_ROXD_R;
                        default: c = K_ROD_R;
                    endcase
                end
            end
            4'hF: c = K_LINE_F;
            default: c = K_ILLEGAL; // lines 0 and 4 decode elsewhere
        endcase
        return c;
    endfunction

    // Stage registers
    logic   pre_valid_reg;
    logic   cand_valid_reg;
    logic   out_valid_reg;
    pre_t   pre_reg;
    pre_t   pre_next;
    cand_t  cand_reg;
    cand_t  cand_next;
    class_t code_reg;
    class_t code_next;
    logic [15:0] out_word_reg;

    // Stage advance: a stage loads when it is empty or its content moves on
    logic adv_out;
    logic adv_cand;
    logic adv_pre;

    assign adv_out      = !out_valid_reg || !result_stall;
    assign adv_cand     = !cand_valid_reg || adv_out;
    assign adv_pre      = !pre_valid_reg || adv_cand;
    assign opcode_stall = !adv_pre;

    // Stage 1: predecode
    always_comb
    begin
        pre_next.word      = opcode_word;
        pre_next.imm       = (opcode_word[5:3] == 3'd7) && (opcode_word[2:0] == 3'd4);
        pre_next.areg      = (opcode_word[5:3] == 3'd1);
        pre_next.word_disp = (opcode_word[7:0] == 8'h00);
    end

    // Stage 2: per-group decode
    always_comb
    begin
        cand_next.word       = pre_reg.word;
        cand_next.bits_class = decode_bits(pre_reg);
        cand_next.misc_class = decode_misc(pre_reg);
        cand_next.rest_class = decode_rest(pre_reg);
    end

    // Stage 3: select by line
    always_comb
    begin
        unique case (cand_reg.word[15:12])
            LINE_BITS: code_next = cand_reg.bits_class;
            LINE_MISC: code_next = cand_reg.misc_class;
            default:   code_next = cand_reg.rest_class;
        endcase
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pre_valid_reg  <= 1'b0;
            cand_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            if (adv_pre)
                pre_valid_reg <= opcode_valid;
            if (adv_cand)
                cand_valid_reg <= pre_valid_reg;
            if (adv_out)
                out_valid_reg <= cand_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv_pre)
            pre_reg <= pre_next;
        if (adv_cand)
            cand_reg <= cand_next;
        if (adv_out) begin
            code_reg     <= code_next;
            out_word_reg <= cand_reg.word;
        end
    end

    // Result transaction
    assign result_valid     = out_valid_reg;
    assign instruction_code = code_reg;
    assign ea_register      = out_word_reg[2:0];
    assign ea_mode          = out_word_reg[5:3];
    assign second_mode      = out_word_reg[8:6];
    assign second_register  = out_word_reg[11:9];
    assign size_bits        = out_word_reg[7:6];
    assign bit_eight        = out_word_reg[8];

endmodule

/* tb/sv/m68k_opcode_class_decoder_tb.sv */
module m68k_opcode_class_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import m68k_ocd_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 10;

    // One decoded opcode: class code plus the split fields
    typedef struct {
        logic [6:0] code;
        logic [2:0] ea_register;
        logic [2:0] ea_mode;
        logic [2:0] second_mode;
        logic [2:0] second_register;
        logic [1:0] size_bits;
        logic       bit_eight;
    } decoded_t;

    // Decode predictor and queue of pending decodes
    class opcode_scoreboard;
        decoded_t    pending_decodes[$];
        int unsigned failures = 0;

        // ORI/ANDI/EORI: immediate source selects the CCR or SR form
        function class_t imm_select(logic to_sr, logic [1:0] sz,
                                    class_t ccr, class_t sr, class_t plain);
            if (!to_sr)
                return plain;
            if (sz == 2'd0)
                return ccr;
            if (sz == 2'd1)
                return sr;
            return K_ILLEGAL;
        endfunction

        function class_t classify_opcode(logic [15:0] w);
            logic [2:0] lo_reg;
            logic [2:0] mode;
            logic [2:0] sreg;
            logic [1:0] sz;
            logic       b8;
            logic       imm;
            logic       areg;
            logic       disp_zero;
            lo_reg    = w[2:0];
            mode      = w[5:3];
            sreg      = w[11:9];
            sz        = w[7:6];
            b8        = w[8];
            imm       = (mode == 3'd7) && (lo_reg == 3'd4);
            areg      = (mode == 3'd1);
            disp_zero = (w[7:0] == 8'h00);
            case (w[15:12])
                4'h0:
                begin
                    if (b8)
                        return areg ? K_MOVEP : class_t'(K_BTST_D + sz);
                    case (sreg)
                        3'd0: return imm_select(imm, sz, K_ORI_CCR, K_ORI_SR, K_ORI);
                        3'd1: return imm_select(imm, sz, K_ANDI_CCR, K_ANDI_SR, K_ANDI);
                        3'd2: return K_SUBI;
                        3'd3: return K_ADDI;
                        3'd4: return class_t'(K_BTST_S + sz);
                        3'd5: return imm_select(imm, sz, K_EORI_CCR, K_EORI_SR, K_EORI);
                        3'd6: return K_CMPI;
                        default: return K_ILLEGAL;
                    endcase
                end
                4'h1, 4'h2, 4'h3:
                    return (w[8:6] == 3'b001) ? K_MOVEA : K_MOVE;
                4'h4:
                begin
                    if (b8)
                    begin
                        if (sz == 2'd3)
                            return K_LEA;
                        if (sz == 2'd2)
                            return K_CHK;
                        return K_ILLEGAL;
                    end
                    if (!w[11])
                    begin
                        if (sz == 2'd3)
                        begin
                            if (sreg == 3'd0)
                                return K_MOVE_FROM_SR;
                            if (sreg == 3'd2)
                                return K_MOVE_TO_CCR;
                            if (sreg == 3'd3)
                                return K_MOVE_TO_SR;
                            return K_ILLEGAL;
                        end
                        return (sreg < 3'd4) ? class_t'(K_NEGX + sreg) : K_ILLEGAL;
                    end
                    if (!w[9])
                    begin
                        if ((w & 16'h01B8) == 16'h0080)
                            return K_EXT;
                        if ((w & 16'h01C0) == 16'h0000)
                            return K_NBCD;
                        if ((w & 16'h01F8) == 16'h0040)
                            return K_SWAP;
                        if ((w & 16'h01C0) == 16'h0040)
                            return K_PEA;
                        if ((w & 16'h0B80) == 16'h0880)
                            return K_MOVEM;
                        return K_ILLEGAL;
                    end
                    // reserved illegal words
                    if (w == 16'h4AFA || w == 16'h4AFB || w == 16'h4AFC)
                        return K_ILLEGAL;
                    if ((w & 16'h0FC0) == 16'h0AC0)
                        return K_TAS;
                    if ((w & 16'h0F00) == 16'h0A00)
                        return K_TST;
                    if ((w & 16'h0FF0) == 16'h0E40)
                        return K_TRAP;
                    if ((w & 16'h0FF8) == 16'h0E50)
                        return K_LINK;
                    if ((w & 16'h0FF8) == 16'h0E58)
                        return K_UNLK;
                    if ((w & 16'h0FF0) == 16'h0E60)
                        return K_MOVE_USP;
                    if ((w & 16'h0FF8) == 16'h0E70)
                    begin
                        case (lo_reg)
                            3'd0: return K_RESET;
                            3'd1: return K_NOP;
                            3'd2: return K_STOP;
                            3'd3: return K_RTE;
                            3'd5: return K_RTS;
                            3'd6: return K_TRAPV;
                            3'd7: return K_RTR;
                            default: return K_ILLEGAL;
                        endcase
                    end
                    if ((w & 16'h0FC0) == 16'h0E80)
                        return K_JSR;
                    if ((w & 16'h0FC0) == 16'h0EC0)
                        return K_JMP;
                    return K_ILLEGAL;
                end
                4'h5:
                begin
                    if (sz == 2'd3)
                        return areg ? K_DBCC : K_SCC;
                    if (areg)
                        return b8 ? K_SUBAQ : K_ADDAQ;
                    return b8 ? K_SUBQ : K_ADDQ;
                end
                4'h6:
                begin
                    if (sreg != 3'd0)
                        return disp_zero ? K_BCC_W : K_BCC_S;
                    if (b8)
                        return disp_zero ? K_BSR_W : K_BSR_S;
                    return disp_zero ? K_BRA_W : K_BRA_S;
                end
                4'h7:
                    return K_MOVEQ;
                4'h8:
                begin
                    if (sz == 2'd3)
                        return b8 ? K_DIVS : K_DIVU;
                    return ((w & 16'h0170) == 16'h0100) ? K_SBCD : K_OR;
                end
                4'h9:
                begin
                    if (sz == 2'd3)
                        return K_SUBA;
                    return ((w & 16'h0130) == 16'h0100) ? K_SUBX : K_SUB;
                end
                4'hA:
                    return K_LINE_A;
                4'hB:
                begin
                    if (sz == 2'd3)
                        return K_CMPA;
                    if (!b8)
                        return K_CMP;
                    return areg ? K_CMPM : K_EOR;
                end
                4'hC:
                begin
                    if (sz == 2'd3)
                        return b8 ? K_MULS : K_MULU;
                    if ((w & 16'h0130) == 16'h0100)
                        return (sz == 2'd0) ? K_ABCD : K_EXG;
                    return K_AND;
                end
                4'hD:
                begin
                    if (sz == 2'd3)
                        return K_ADDA;
                    return ((w & 16'h0130) == 16'h0100) ? K_ADDX : K_ADD;
                end
                4'hE:
                begin
                    if (sz == 2'd3)
                        return (sreg < 3'd4) ? class_t'(K_ASD_M + sreg) : K_ILLEGAL;
                    return class_t'(K_ASD_R + w[4:3]);
                end
                default:
                    return K_LINE_F;
            endcase
        endfunction

        function void note_opcode(logic [15:0] w);
            decoded_t d;
            d.code            = classify_opcode(w);
            d.ea_register     = w[2:0];
            d.ea_mode         = w[5:3];
            d.second_mode     = w[8:6];
            d.second_register = w[11:9];
            d.size_bits       = w[7:6];
            d.bit_eight       = w[8];
            pending_decodes.push_back(d);
        endfunction

        function void compare_field(string field, int expected, int actual);
            if (expected !== actual)
            begin
                $error("%s: expected %0d, actual %0d", field, expected, actual);
                failures++;
            end
        endfunction

        function void check_result(decoded_t got);
            decoded_t exp;
            if (pending_decodes.size() == 0)
            begin
                $error("result transaction with no opcode pending");
                failures++;
                return;
            end
            exp = pending_decodes.pop_front();
            compare_field("instruction_code", exp.code, got.code);
            compare_field("ea_register", exp.ea_register, got.ea_register);
            compare_field("ea_mode", exp.ea_mode, got.ea_mode);
            compare_field("second_mode", exp.second_mode, got.second_mode);
            compare_field("second_register", exp.second_register, got.second_register);
            compare_field("size_bits", exp.size_bits, got.size_bits);
            compare_field("bit_eight", exp.bit_eight, got.bit_eight);
        endfunction

        function int pending();
            return pending_decodes.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        opcode_valid = 1'b0;
    logic        opcode_stall;
    logic [15:0] opcode_word = 16'h0000;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [6:0]  instruction_code;
    logic [2:0]  ea_register;
    logic [2:0]  ea_mode;
    logic [2:0]  second_mode;
    logic [2:0]  second_register;
    logic [1:0]  size_bits;
    logic        bit_eight;

    opcode_scoreboard sb = new();
    int idle_pct = 0;
    int stall_pct = 0;
    bit hold_request = 1'b0;
    int quiet_cycles = 0;

    m68k_opcode_class_decoder uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .opcode_valid     (opcode_valid),
        .opcode_stall     (opcode_stall),
        .opcode_word      (opcode_word),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .instruction_code (instruction_code),
        .ea_register      (ea_register),
        .ea_mode          (ea_mode),
        .second_mode      (second_mode),
        .second_register  (second_register),
        .size_bits        (size_bits),
        .bit_eight        (bit_eight)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Monitor both channels at the clock edge; also tracks idle cycles
    always @(posedge clk)
    begin
        decoded_t got;
        if (rst_n)
        begin
            if (opcode_valid && !opcode_stall)
                sb.note_opcode(opcode_word);
            if (result_valid && !result_stall)
            begin
                got.code            = instruction_code;
                got.ea_register     = ea_register;
                got.ea_mode         = ea_mode;
                got.second_mode     = second_mode;
                got.second_register = second_register;
                got.size_bits       = size_bits;
                got.bit_eight       = bit_eight;
                sb.check_result(got);
            end
        end
        if ((opcode_valid && !opcode_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Watchdog: too long with no transaction on either channel
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random stall, or a long hold-off on request
    initial
    begin
        int held;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                result_stall <= 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            else
                result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offer one opcode, with random idle cycles first, and wait for acceptance
    task automatic send_opcode(input logic [15:0] w);
        while ($urandom_range(99) < idle_pct)
        begin
            opcode_valid <= 1'b0;
            @(posedge clk);
        end
        opcode_valid <= 1'b1;
        opcode_word  <= w;
        do
            @(posedge clk);
        while (opcode_stall);
    endtask

    // Random opcode, biased toward the narrow encodings of lines 0, 4 and 6
    function automatic logic [15:0] random_opcode();
        logic [3:0]  line;
        logic [15:0] w;
        logic [15:0] base;
        logic [15:0] free;
        line = 4'($urandom_range(15));
        w    = {line, 12'($urandom)};
        if (line == 4'h4 && $urandom_range(1) == 1)
        begin
            case ($urandom_range(11))
                0:  begin base = 16'h4E70; free = 16'h0007; end
                1:  begin base = 16'h4E40; free = 16'h000F; end
                2:  begin base = 16'h4E50; free = 16'h000F; end
                3:  begin base = 16'h4E60; free = 16'h000F; end
                4:  begin base = 16'h4E80; free = 16'h007F; end
                5:  begin base = 16'h4AC0; free = 16'h003F; end
                6:  begin base = 16'h4AF8; free = 16'h0007; end
                7:  begin base = 16'h4A00; free = 16'h00FF; end
                8:  begin base = 16'h4880; free = 16'h0047; end
                9:  begin base = 16'h4840; free = 16'h0007; end
                10: begin base = 16'h4880; free = 16'h047F; end
                default: begin base = 16'h40C0; free = 16'h0E3F; end
            endcase
            w = base | (16'($urandom) & free);
        end
        if (line == 4'h0 && $urandom_range(3) == 0)
            w[5:0] = 6'h3C;
        if (line == 4'h6 && $urandom_range(2) == 0)
            w[7:0] = 8'h00;
        return w;
    endfunction

    task automatic run_phase(input int n, input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n)
            send_opcode(random_opcode());
    endtask

    // Stimulus
    initial
    begin
        logic [15:0] directed[$];
        directed = '{16'h0000, 16'hFFFF, 16'h4AFA, 16'h4AFB, 16'h4AFC, 16'h4AFD,
                     16'hA000, 16'hAFFF, 16'hF000, 16'h4E70, 16'h4E71, 16'h4E72,
                     16'h4E73, 16'h4E74, 16'h4E75, 16'h4E76, 16'h4E77, 16'h0108,
                     16'h003C, 16'h007C, 16'h00BC, 16'h0E00, 16'h6000, 16'h6101,
                     16'h5555};
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words: extremes and the special encodings
        foreach (directed[i])
            send_opcode(directed[i]);

        run_phase(140, 0, 0);
        run_phase(110, 78, 0);
        run_phase(110, 0, 78);
        run_phase(120, 33, 33);

        // receiver holds off while the sender keeps pushing
        hold_request = 1'b1;
        run_phase(50, 0, 0);
        opcode_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
